FILE: design/tsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the triangle stiffness block
// Field widths of the vertex and result transactions, internal datapath
// widths, the entry index tables and the status structs between modules.
// ----------------------------------------------------------------------------
package tsf_pkg;

    // transaction field widths
    localparam int COORD_W = 32;
    localparam int K_W     = 32;

    // datapath widths: vertex differences, products, sums of two products
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    // magnitude of a sum of two products never exceeds 2^65
    localparam int MAG_W   = PROD_W;
    // divisor is twice the determinant magnitude
    localparam int DEN_W   = MAG_W + 1;
    // quotient bits kept: one beyond the result width to see clipping
    localparam int QW      = K_W + 1;

    localparam int N_ENT   = 6;

    // clipping limits for positive and negative entries
    localparam logic [QW-1:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [QW-1:0] LIM_NEG = 33'h0_8000_0000;

    // row and column of each entry: k00 k01 k02 k11 k12 k22
    localparam int ENT_I [N_ENT] = '{0, 0, 0, 1, 1, 2};
    localparam int ENT_J [N_ENT] = '{0, 1, 2, 1, 2, 2};

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic        [MAG_W-1:0]   t_mag;
    typedef logic signed [K_W-1:0]     t_k;

    typedef struct packed {
        t_coord v0x;
        t_coord v0y;
        t_coord v1x;
        t_coord v1y;
        t_coord v2x;
        t_coord v2y;
    } t_tri;

    // control travelling into one divider lane
    typedef struct packed {
        logic vld;
        logic degen;
        logic neg;
    } t_div_ctl;

    // status leaving one divider lane
    typedef struct packed {
        logic vld;
        logic degen;
        logic sat;
    } t_div_sts;

    typedef struct packed {
        t_k   k00;
        t_k   k01;
        t_k   k02;
        t_k   k11;
        t_k   k12;
        t_k   k22;
        logic degenerate;
        logic saturated;
    } t_result;

endpackage

FILE: design/tsf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_if: valid/ready channels of the triangle stiffness block
// tsf_in_if carries one triangle, tsf_out_if carries one element matrix.
// ----------------------------------------------------------------------------
interface tsf_in_if import tsf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vertex0_x;
    t_coord vertex0_y;
    t_coord vertex1_x;
    t_coord vertex1_y;
    t_coord vertex2_x;
    t_coord vertex2_y;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
        input  ready
    );
    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
        output ready
    );
endinterface

interface tsf_out_if import tsf_pkg::*; ();
    logic valid;
    logic ready;
    t_k   k00;
    t_k   k01;
    t_k   k02;
    t_k   k11;
    t_k   k12;
    t_k   k22;
    logic degenerate;
    logic saturated;

    modport source (
        output valid, k00, k01, k02, k11, k12, k22, degenerate, saturated,
        input  ready
    );
    modport sink (
        input  valid, k00, k01, k02, k11, k12, k22, degenerate, saturated,
        output ready
    );
endinterface

FILE: design/tsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_front: geometry front end, four pipeline stages
// Vertex differences, gradient products, determinant and numerator sums,
// then sign and magnitude of each for the divider lanes.
// ----------------------------------------------------------------------------
module tsf_front import tsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_tri               i_tri,
    output logic               o_vld,
    output logic               o_degen,
    output t_mag               o_dmag,
    output t_mag               o_nmag [N_ENT],
    output logic [N_ENT-1:0]   o_nneg
);

    localparam int LAT = 4;

    logic [LAT-1:0] r_vld;

    t_diff w_b [3];
    t_diff w_c [3];
    t_diff r_b [3];
    t_diff r_c [3];

    t_prod r_pd1;
    t_prod r_pd2;
    t_prod r_pb [N_ENT];
    t_prod r_pc [N_ENT];

    t_sum  r_d;
    t_sum  r_n [N_ENT];

    t_sum  w_dabs;
    t_sum  w_nabs [N_ENT];

    t_mag             r_dmag;
    logic             r_degen;
    t_mag             r_nmag [N_ENT];
    logic [N_ENT-1:0] r_nneg;

    // advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    // stage 1: gradient components from vertex differences
    always_comb begin
        w_b[0] = t_diff'(i_tri.v1y) - t_diff'(i_tri.v2y);
        w_b[1] = t_diff'(i_tri.v2y) - t_diff'(i_tri.v0y);
        w_b[2] = t_diff'(i_tri.v0y) - t_diff'(i_tri.v1y);
        w_c[0] = t_diff'(i_tri.v2x) - t_diff'(i_tri.v1x);
        w_c[1] = t_diff'(i_tri.v0x) - t_diff'(i_tri.v2x);
        w_c[2] = t_diff'(i_tri.v1x) - t_diff'(i_tri.v0x);
    end

    // stage 4: sign and magnitude of determinant and numerators
    always_comb begin
        w_dabs = r_d[SUM_W-1] ? -r_d : r_d;
        for (int k = 0; k < N_ENT; k++) begin
            w_nabs[k] = r_n[k][SUM_W-1] ? -r_n[k] : r_n[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_b <= w_b;
            r_c <= w_c;
            // stage 2: one signed 33x33 product per term
            r_pd1 <= r_b[1] * r_c[2];
            r_pd2 <= r_b[2] * r_c[1];
            for (int k = 0; k < N_ENT; k++) begin
                r_pb[k] <= r_b[ENT_I[k]] * r_b[ENT_J[k]];
                r_pc[k] <= r_c[ENT_I[k]] * r_c[ENT_J[k]];
            end
            // stage 3: twice the signed area and the numerators
            r_d <= t_sum'(r_pd1) - t_sum'(r_pd2);
            for (int k = 0; k < N_ENT; k++) begin
                r_n[k] <= t_sum'(r_pb[k]) + t_sum'(r_pc[k]);
            end
            // stage 4
            r_dmag  <= w_dabs[MAG_W-1:0];
            r_degen <= (r_d == '0);
            for (int k = 0; k < N_ENT; k++) begin
                r_nmag[k] <= w_nabs[k][MAG_W-1:0];
                r_nneg[k] <= r_n[k][SUM_W-1];
            end
        end
    end

    assign o_vld   = r_vld[LAT-1];
    assign o_degen = r_degen;
    assign o_dmag  = r_dmag;
    assign o_nmag  = r_nmag;
    assign o_nneg  = r_nneg;

endmodule

FILE: design/tsf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_div: pipelined rounding divider for one stiffness entry
// Forms (|n| * 2^FRAC_BITS + |D|) / (2 |D|) with a restoring division,
// one quotient bit per stage, then clips and applies the sign.
// ----------------------------------------------------------------------------
module tsf_div import tsf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_ctl i_ctl,
    input  t_mag     i_nmag,
    input  t_mag     i_dmag,
    output t_div_sts o_sts,
    output t_k       o_k
);

    localparam int NUM_W = MAG_W + FRAC_BITS + 1;
    localparam int HI_W  = NUM_W - QW;

    // stage A: rounded numerator and divisor
    logic             r_a_vld;
    logic             r_a_degen;
    logic             r_a_neg;
    logic [NUM_W-1:0] r_a_num;
    logic [DEN_W-1:0] r_a_den;
    logic [NUM_W-1:0] w_num;

    // stage B and the bit stages
    logic [DEN_W-1:0] w_p0;
    logic             r_vld   [0:QW];
    logic             r_degen [0:QW];
    logic             r_neg   [0:QW];
    logic             r_ovf   [0:QW];
    logic [QW-1:0]    r_q     [0:QW];
    logic [DEN_W-1:0] r_den   [0:QW-1];
    logic [DEN_W-1:0] r_rem   [0:QW-1];
    logic [QW-1:0]    r_low   [0:QW-1];

    // output stage
    logic [QW-1:0]    w_lim;
    logic             w_sat;
    logic [QW-1:0]    w_mag;
    logic [K_W-1:0]   w_mag_k;
    logic [K_W-1:0]   w_val;
    logic             r_o_vld;
    logic             r_o_degen;
    logic             r_o_sat;
    t_k               r_o_k;

    assign w_num = (NUM_W'(i_nmag) << FRAC_BITS) + NUM_W'(i_dmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_degen <= i_ctl.degen;
            r_a_neg   <= i_ctl.neg;
            r_a_num   <= w_num;
            r_a_den   <= {i_dmag, 1'b0};
        end
    end

    // stage B: quotient above the kept bits means the entry clips
    assign w_p0 = DEN_W'(r_a_num[NUM_W-1 -: HI_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_degen[0] <= r_a_degen;
            r_neg[0]   <= r_a_neg;
            r_ovf[0]   <= (w_p0 >= r_a_den);
            r_q[0]     <= '0;
            r_den[0]   <= r_a_den;
            r_rem[0]   <= w_p0;
            r_low[0]   <= r_a_num[QW-1:0];
        end
    end

    // bit stages: shift in one numerator bit, subtract the divisor if it fits
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [DEN_W:0] w_trial;
        logic [DEN_W:0] w_diff;
        logic           w_qbit;

        assign w_trial = {r_rem[s], r_low[s][QW-1]};
        assign w_diff  = w_trial - {1'b0, r_den[s]};
        assign w_qbit  = !w_diff[DEN_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_degen[s+1] <= r_degen[s];
                r_neg[s+1]   <= r_neg[s];
                r_ovf[s+1]   <= r_ovf[s];
                r_q[s+1]     <= {r_q[s][QW-2:0], w_qbit};
            end
        end

        // hold remainder and divisor only while bits remain
        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= w_qbit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_low[s+1] <= {r_low[s][QW-2:0], 1'b0};
                    r_den[s+1] <= r_den[s];
                end
            end
        end
    end

    // output stage: clip to range, apply sign, zero a degenerate triangle
    always_comb begin
        w_lim   = r_neg[QW] ? LIM_NEG : LIM_POS;
        w_sat   = r_ovf[QW] || (r_q[QW] > w_lim);
        w_mag   = w_sat ? w_lim : r_q[QW];
        w_mag_k = w_mag[K_W-1:0];
        w_val   = r_neg[QW] ? (~w_mag_k + 1'b1) : w_mag_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_degen <= r_degen[QW];
            r_o_sat   <= !r_degen[QW] && w_sat;
            r_o_k     <= r_degen[QW] ? '0 : $signed(w_val);
        end
    end

    assign o_sts = '{vld: r_o_vld, degen: r_o_degen, sat: r_o_sat};
    assign o_k   = r_o_k;

endmodule

FILE: design/tsf_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_outq: two-entry output queue
// Head register drives the output channel, a skid register catches the
// transaction that arrives while the head waits.
// ----------------------------------------------------------------------------
module tsf_outq import tsf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_head;
    t_result    r_skid;
    logic       w_pop;

    assign w_pop = (r_cnt != CNT_EMPTY) && i_ready;
    assign n_cnt = r_cnt + 2'(i_push) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_EMPTY;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // fill the head when it frees up, else park in the skid register
    always_ff @(posedge i_clk) begin
        if (i_push && ((r_cnt == CNT_EMPTY) || ((r_cnt == CNT_ONE) && w_pop))) begin
            r_head <= i_data;
        end else if (w_pop && (r_cnt == CNT_FULL)) begin
            r_head <= r_skid;
        end
        if (i_push && (r_cnt == CNT_ONE) && !w_pop) begin
            r_skid <= i_data;
        end
    end

    assign o_room  = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != CNT_EMPTY);
    assign o_data  = r_head;

endmodule

FILE: design/p1_triangle_stiffness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1_triangle_stiffness: P1 Laplace element stiffness of one triangle
// Takes three vertices and returns the six distinct entries of the
// symmetric 3x3 element matrix, rounded and clipped Q16.16.
//
//   channel   dir   modport      transaction
//   i_tri     in    sink         vertex0..2 x/y, signed Q16.16
//   o_stiff   out   source       k00 k01 k02 k11 k12 k22, degenerate, saturated
//
// One triangle per cycle while the output queue has room. The path to
// o_stiff.valid runs through 41 register stages, the first loading on the
// accepting edge: 4 front-end stages, 36 divider stages (operand setup, range
// check, one stage for each of the 33 quotient bits, clip and sign) and the
// output queue.
// Reset clears the valid bits and the queue count only.
// The whole pipeline holds while two results wait in the output queue;
// i_tri.ready is low exactly then.
// ----------------------------------------------------------------------------
module p1_triangle_stiffness import tsf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsf_in_if.sink    i_tri,
    tsf_out_if.source o_stiff
);

    logic             w_room;
    logic             w_en;
    t_tri             w_tri;

    logic             f_vld;
    logic             f_degen;
    t_mag             f_dmag;
    t_mag             f_nmag [N_ENT];
    logic [N_ENT-1:0] f_nneg;

    t_div_sts         w_sts [N_ENT];
    t_k               w_k   [N_ENT];
    logic [N_ENT-1:0] w_vld;
    logic [N_ENT-1:0] w_dg;
    logic [N_ENT-1:0] w_sat;
    logic             w_push;
    t_result          w_res;
    t_result          w_out;

    // advance every stage only while the output queue has room
    assign w_en        = w_room;
    assign i_tri.ready = w_room;

    assign w_tri = '{v0x: i_tri.vertex0_x, v0y: i_tri.vertex0_y,
                     v1x: i_tri.vertex1_x, v1y: i_tri.vertex1_y,
                     v2x: i_tri.vertex2_x, v2y: i_tri.vertex2_y};

    tsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_tri.valid),
        .i_tri   (w_tri),
        .o_vld   (f_vld),
        .o_degen (f_degen),
        .o_dmag  (f_dmag),
        .o_nmag  (f_nmag),
        .o_nneg  (f_nneg)
    );

    // one divider lane per matrix entry
    for (genvar k = 0; k < N_ENT; k++) begin : g_lane
        t_div_ctl w_ctl;

        assign w_ctl = '{vld: f_vld, degen: f_degen, neg: f_nneg[k]};

        tsf_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl),
            .i_nmag  (f_nmag[k]),
            .i_dmag  (f_dmag),
            .o_sts   (w_sts[k]),
            .o_k     (w_k[k])
        );

        assign w_vld[k] = w_sts[k].vld;
        assign w_dg[k]  = w_sts[k].degen;
        assign w_sat[k] = w_sts[k].sat;
    end

    // gather the lanes into one result transaction
    assign w_push = w_en && (&w_vld);
    assign w_res  = '{k00: w_k[0], k01: w_k[1], k02: w_k[2],
                      k11: w_k[3], k12: w_k[4], k22: w_k[5],
                      degenerate: &w_dg, saturated: |w_sat};

    tsf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_room  (w_room),
        .o_valid (o_stiff.valid),
        .o_data  (w_out),
        .i_ready (o_stiff.ready)
    );

    assign o_stiff.k00        = w_out.k00;
    assign o_stiff.k01        = w_out.k01;
    assign o_stiff.k02        = w_out.k02;
    assign o_stiff.k11        = w_out.k11;
    assign o_stiff.k12        = w_out.k12;
    assign o_stiff.k22        = w_out.k22;
    assign o_stiff.degenerate = w_out.degenerate;
    assign o_stiff.saturated  = w_out.saturated;

    // lanes run in lockstep
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_vld) |-> (&w_vld))
        else $error("divider lanes out of step");

    // a degenerate triangle gives zero entries and no clipping
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stiff.valid && o_stiff.degenerate) |->
        (!o_stiff.saturated && o_stiff.k00 == '0 && o_stiff.k01 == '0 &&
         o_stiff.k02 == '0 && o_stiff.k11 == '0 && o_stiff.k12 == '0 &&
         o_stiff.k22 == '0))
        else $error("degenerate result not cleared");

    // diagonal numerators are sums of squares
    a_diag_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stiff.valid |->
        (!o_stiff.k00[K_W-1] && !o_stiff.k11[K_W-1] && !o_stiff.k22[K_W-1]))
        else $error("negative diagonal entry");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stiff.valid)
        else $error("output valid after reset");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the P1 triangle stiffness block
// Streams triangles into the block: directed shapes (unit and mirrored
// triangles, degenerate and collinear ones, coordinate extremes, slivers
// that clip), a receiver hold-off that fills the pipeline, then random
// triangles of several kinds. Each element matrix is predicted with exact
// wide integer arithmetic and compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top import tsf_pkg::*; ();

    localparam int FRAC       = 16;
    localparam int CLK_HALF   = 2;
    localparam int DRAIN_CYC  = 60;
    localparam int PRINT_CAP  = 200;
    localparam int C_MIN      = 32'h8000_0000;
    localparam int C_MAX      = 32'h7FFF_FFFF;
    localparam int C_ONE      = 32'h0001_0000;

    logic i_clk;
    logic i_rst_n;

    tsf_in_if  tri_ch ();
    tsf_out_if stiff_ch ();

    p1_triangle_stiffness #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch),
        .o_stiff (stiff_ch)
    );

    // expected element matrices, oldest first
    t_result pending_matrices [$];

    bit calm;        // no random idling on either side while set
    int hold_off;    // receiver stall cycles still to run
    int error_count;
    int printed;
    int accepted;
    int checked;
    int degen_seen;
    int clipped_seen;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // one entry: (bi*bj + ci*cj) / (2|D|) scaled, rounded, clipped; MSB = clip
    function automatic logic [K_W:0] rounded_entry(input t_diff bi, input t_diff bj,
                                                   input t_diff ci, input t_diff cj,
                                                   input logic [127:0] den);
        t_sum         num;
        t_sum         num_abs;
        logic [127:0] quo;
        logic [127:0] lim;
        logic         neg;
        logic         clip;
        num     = t_sum'(bi) * t_sum'(bj) + t_sum'(ci) * t_sum'(cj);
        neg     = num < 0;
        num_abs = neg ? -num : num;
        quo     = ((128'($unsigned(num_abs)) << FRAC) + den) / (den << 1);
        lim     = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        clip    = quo > lim;
        if (clip) begin
            quo = lim;
        end
        if (neg) begin
            quo = -quo;
        end
        return {clip, quo[K_W-1:0]};
    endfunction

    function automatic t_result stiffness_of(input t_tri s);
        t_diff            b0, b1, b2, c0, c1, c2;
        t_sum             det;
        t_sum             det_abs;
        logic [127:0]     den;
        logic [K_W:0]     e [6];
        t_result          r;
        b0 = t_diff'($signed(s.v1y)) - t_diff'($signed(s.v2y));
        b1 = t_diff'($signed(s.v2y)) - t_diff'($signed(s.v0y));
        b2 = t_diff'($signed(s.v0y)) - t_diff'($signed(s.v1y));
        c0 = t_diff'($signed(s.v2x)) - t_diff'($signed(s.v1x));
        c1 = t_diff'($signed(s.v0x)) - t_diff'($signed(s.v2x));
        c2 = t_diff'($signed(s.v1x)) - t_diff'($signed(s.v0x));
        det = t_sum'(b1) * t_sum'(c2) - t_sum'(b2) * t_sum'(c1);
        r = '0;
        if (det == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        det_abs = det < 0 ? -det : det;
        den     = 128'($unsigned(det_abs));
        e[0] = rounded_entry(b0, b0, c0, c0, den);
        e[1] = rounded_entry(b0, b1, c0, c1, den);
        e[2] = rounded_entry(b0, b2, c0, c2, den);
        e[3] = rounded_entry(b1, b1, c1, c1, den);
        e[4] = rounded_entry(b1, b2, c1, c2, den);
        e[5] = rounded_entry(b2, b2, c2, c2, den);
        r.k00 = e[0][K_W-1:0];
        r.k01 = e[1][K_W-1:0];
        r.k02 = e[2][K_W-1:0];
        r.k11 = e[3][K_W-1:0];
        r.k12 = e[4][K_W-1:0];
        r.k22 = e[5][K_W-1:0];
        r.saturated = e[0][K_W] | e[1][K_W] | e[2][K_W] | e[3][K_W] | e[4][K_W] | e[5][K_W];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    initial begin
        #(4 * 400000);
        $display("%0t ns: timeout with %0d matrices outstanding", $time,
                 pending_matrices.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        stiff_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off       = hold_off - 1;
                stiff_ch.ready <= 1'b0;
            end else begin
                stiff_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [K_W-1:0] exp_v,
                               input logic [K_W-1:0] act_v, inout bit bad);
        if (exp_v !== act_v) begin
            bad = 1'b1;
            if (printed < PRINT_CAP) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
            printed++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_m;
        bit      bad;
        if (i_rst_n && stiff_ch.valid && stiff_ch.ready) begin
            if (pending_matrices.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual k00 %h",
                         $time, stiff_ch.k00);
            end else begin
                exp_m = pending_matrices.pop_front();
                bad   = 1'b0;
                check_field("k00", exp_m.k00, stiff_ch.k00, bad);
                check_field("k01", exp_m.k01, stiff_ch.k01, bad);
                check_field("k02", exp_m.k02, stiff_ch.k02, bad);
                check_field("k11", exp_m.k11, stiff_ch.k11, bad);
                check_field("k12", exp_m.k12, stiff_ch.k12, bad);
                check_field("k22", exp_m.k22, stiff_ch.k22, bad);
                check_field("degenerate", K_W'(exp_m.degenerate),
                            K_W'(stiff_ch.degenerate), bad);
                check_field("saturated", K_W'(exp_m.saturated),
                            K_W'(stiff_ch.saturated), bad);
                if (bad) begin
                    error_count++;
                end
                checked++;
                degen_seen   += exp_m.degenerate;
                clipped_seen += exp_m.saturated;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one triangle, hold it until the transaction completes
    task automatic send_tri(input t_tri s);
        while (!calm && $urandom_range(0, 99) < 16) begin
            tri_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_ch.valid     <= 1'b1;
        tri_ch.vertex0_x <= s.v0x;
        tri_ch.vertex0_y <= s.v0y;
        tri_ch.vertex1_x <= s.v1x;
        tri_ch.vertex1_y <= s.v1y;
        tri_ch.vertex2_x <= s.v2x;
        tri_ch.vertex2_y <= s.v2y;
        @(posedge i_clk);
        while (!tri_ch.ready) begin
            @(posedge i_clk);
        end
        // queue the expected matrix behind the older ones
        pending_matrices = {pending_matrices, stiffness_of(s)};
        accepted++;
    endtask

    task automatic send_coords(input int x0, input int y0, input int x1,
                               input int y1, input int x2, input int y2);
        t_tri s;
        s = '{v0x: x0, v0y: y0, v1x: x1, v1y: y1, v2x: x2, v2y: y2};
        send_tri(s);
    endtask

    // a coordinate biased toward the extremes
    function automatic int edge_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        calm = 1'b0;
        // unit right triangle and its mirror
        send_coords(0, 0, C_ONE, 0, 0, C_ONE);
        send_coords(0, 0, 0, C_ONE, C_ONE, 0);
        // same shape at one LSB, and at -1 offsets
        send_coords(0, 0, 1, 0, 0, 1);
        send_coords(-1, -1, 0, -1, -1, 0);
        // near-equilateral
        send_coords(0, 0, 2 * C_ONE, 0, C_ONE, 113512);
        // degenerate: all zero, one repeated point, collinear, all max, all min
        send_coords(0, 0, 0, 0, 0, 0);
        send_coords(12345, -678, 12345, -678, 12345, -678);
        send_coords(0, 0, C_ONE, C_ONE, 2 * C_ONE, 2 * C_ONE);
        send_coords(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_coords(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_coords(C_MIN, C_MIN, 0, 0, C_MAX, C_MAX);
        // widest right triangles
        send_coords(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX);
        send_coords(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN);
        // slivers: entries clip both ways
        send_coords(C_MIN, 0, C_MAX, 0, 0, 1);
        send_coords(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN + 1);
        send_coords(0, 0, C_ONE, 0, C_ONE / 2, 1);
        send_coords(0, 0, C_ONE, 0, C_ONE / 2, 3);
        // alternating bit patterns
        send_coords(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'hFFFF_0000, 32'h0000_FFFF);
        send_coords(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    endtask

    // stall the receiver long enough for the pipeline to fill and block input
    task automatic test_backpressure();
        t_tri s;
        calm     = 1'b1;
        hold_off = 200;
        repeat (60) begin
            s = '{v0x: $urandom, v0y: $urandom, v1x: $urandom,
                  v1y: $urandom, v2x: $urandom, v2y: $urandom};
            send_tri(s);
        end
    endtask

    task automatic send_random_tri();
        t_tri s;
        int   bx, by, span, dx, dy, k;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                s = '{v0x: $urandom, v0y: $urandom, v1x: $urandom,
                      v1y: $urandom, v2x: $urandom, v2y: $urandom};
            end
            3, 4: begin
                // small triangle around a random point
                bx   = $signed($urandom) >>> 1;
                by   = $signed($urandom) >>> 1;
                span = 1 << $urandom_range(0, 24);
                s.v0x = bx;
                s.v0y = by;
                s.v1x = bx + int'($urandom_range(0, 2 * span)) - span;
                s.v1y = by + int'($urandom_range(0, 2 * span)) - span;
                s.v2x = bx + int'($urandom_range(0, 2 * span)) - span;
                s.v2y = by + int'($urandom_range(0, 2 * span)) - span;
            end
            5: begin
                // collinear: third point a multiple along the first edge
                bx = $signed($urandom) >>> 2;
                by = $signed($urandom) >>> 2;
                dx = int'($urandom_range(0, 2_000_000)) - 1_000_000;
                dy = int'($urandom_range(0, 2_000_000)) - 1_000_000;
                k  = int'($urandom_range(0, 6)) - 3;
                s = '{v0x: bx, v0y: by, v1x: bx + dx, v1y: by + dy,
                      v2x: bx + k * dx, v2y: by + k * dy};
            end
            6: begin
                // two vertices coincide
                s = '{v0x: $urandom, v0y: $urandom, v1x: $urandom,
                      v1y: $urandom, v2x: 0, v2y: 0};
                if ($urandom_range(0, 1)) begin
                    s.v2x = s.v0x;
                    s.v2y = s.v0y;
                end else begin
                    s.v2x = s.v1x;
                    s.v2y = s.v1y;
                end
            end
            7: begin
                // sliver: third vertex near the midpoint of the first edge
                s.v0x = $urandom;
                s.v0y = $urandom;
                s.v1x = $urandom;
                s.v1y = $urandom;
                s.v2x = t_coord'((longint'(s.v0x) + longint'(s.v1x)) / 2)
                        + t_coord'($urandom_range(0, 6)) - 3;
                s.v2y = t_coord'((longint'(s.v0y) + longint'(s.v1y)) / 2)
                        + t_coord'($urandom_range(0, 6)) - 3;
            end
            8: begin
                // axis-aligned right triangle on a whole-unit grid
                bx   = (int'($urandom_range(0, 200)) - 100) * C_ONE;
                by   = (int'($urandom_range(0, 200)) - 100) * C_ONE;
                dx   = (int'($urandom_range(1, 16))) * C_ONE;
                dy   = (int'($urandom_range(1, 16))) * C_ONE;
                s = '{v0x: bx, v0y: by, v1x: bx + dx, v1y: by,
                      v2x: bx, v2y: by + dy};
            end
            default: begin
                s = '{v0x: edge_coord(), v0y: edge_coord(), v1x: edge_coord(),
                      v1y: edge_coord(), v2x: edge_coord(), v2y: edge_coord()};
            end
        endcase
        send_tri(s);
    endtask

    task automatic test_random();
        calm = 1'b0;
        repeat (350) begin
            send_random_tri();
        end
        // long stretch at full rate on both sides
        calm = 1'b1;
        repeat (200) begin
            send_random_tri();
        end
        calm = 1'b0;
        repeat (320) begin
            send_random_tri();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        tri_ch.valid     <= 1'b0;
        tri_ch.vertex0_x <= '0;
        tri_ch.vertex0_y <= '0;
        tri_ch.vertex1_x <= '0;
        tri_ch.vertex1_y <= '0;
        tri_ch.vertex2_x <= '0;
        tri_ch.vertex2_y <= '0;
        calm     = 1'b0;
        hold_off = 0;
        repeat (9) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();

        // drop valid and drain
        tri_ch.valid <= 1'b0;
        calm = 1'b1;
        while (pending_matrices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) begin
            @(posedge i_clk);
        end

        $display("%0d triangles sent, %0d element matrices checked", accepted, checked);
        $display("%0d degenerate, %0d with clipped entries, %0d bad results",
                 degen_seen, clipped_seen, error_count);
        if (error_count == 0 && pending_matrices.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/tsf_pkg.sv
design/tsf_if.sv
design/tsf_front.sv
design/tsf_div.sv
design/tsf_outq.sv
design/p1_triangle_stiffness.sv
sim/tb_top.sv
